// ===== rtl/dvu_pkg.sv =====
// Shared types and constants of the Doppler velocity unfold unit.
// Holds register codes, register widths, controller states and control structs.
// Depends on nothing.
`timescale 1ns / 1ps

package dvu_pkg;

  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 24;
  localparam int AvgCntW   = 7;
  localparam int AvgRecW   = 17;
  localparam int FoldIntW  = 14;
  localparam int FoldRecW  = 24;
  localparam int FoldLimW  = 4;
  localparam int FoldW     = 5;

  localparam logic [AvgCntW-1:0]  AvgCntRst  = 7'd5;
  localparam logic [AvgRecW-1:0]  AvgRecRst  = 17'd13107;
  localparam logic [FoldIntW-1:0] FoldIntRst = 14'd2000;
  localparam logic [FoldRecW-1:0] FoldRecRst = 24'd8389;
  localparam logic [FoldLimW-1:0] FoldLimRst = 4'd15;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_INIT_MODE,
    CFG_AVG_COUNT,
    CFG_AVG_RECIP,
    CFG_FOLD_INTERVAL,
    CFG_FOLD_RECIP,
    CFG_MAX_POS_FOLDS,
    CFG_MAX_NEG_FOLDS
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_MUL1_LO,
    ST_MUL1_HI,
    ST_DIFF,
    ST_MUL2_LO,
    ST_MUL2_HI,
    ST_FOLD,
    ST_UPDATE,
    ST_LOAD
  } ctrl_state_e;

  typedef enum logic [1:0] {
    MUL_IDLE,
    MUL_LO,
    MUL_HI
  } mul_op_e;

  typedef enum logic {
    SEL_AVG,
    SEL_FOLD
  } mul_sel_e;

  typedef struct packed {
    logic                init_mode;
    logic [AvgCntW-1:0]  avg_count;
    logic [AvgRecW-1:0]  avg_reciprocal;
    logic [FoldIntW-1:0] fold_interval;
    logic [FoldRecW-1:0] fold_reciprocal;
    logic [FoldLimW-1:0] max_pos_folds;
    logic [FoldLimW-1:0] max_neg_folds;
  } cfg_t;

  typedef struct packed {
    logic     accept;
    logic     clear;
    logic     fill;
    logic     rd;
    mul_op_e  mul_op;
    mul_sel_e mul_sel;
    logic     diff;
    logic     fold;
    logic     upd;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic seed_now;
    logic proc_now;
    logic proc_q;
    logic fill_last;
    logic clear_last;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/dvu_gate_if.sv =====
// Input channel of the Doppler velocity unfold unit: one radar gate per transfer.
// Carries valid, ready and the gate fields; no dependencies.
`timescale 1ns / 1ps

interface dvu_gate_if #(
  parameter int VEL_WIDTH = 16
) ();
  logic                        valid;
  logic                        ready;
  logic signed [VEL_WIDTH-1:0] gate_velocity;
  logic                        gate_missing;
  logic                        in_boundary;
  logic                        ray_start;
  logic                        sweep_start;
  logic signed [VEL_WIDTH-1:0] wind_velocity;

  modport source (
    output valid, gate_velocity, gate_missing, in_boundary, ray_start, sweep_start,
           wind_velocity,
    input  ready
  );

  modport sink (
    input  valid, gate_velocity, gate_missing, in_boundary, ray_start, sweep_start,
           wind_velocity,
    output ready
  );
endinterface

// ===== rtl/dvu_result_if.sv =====
// Output channel of the Doppler velocity unfold unit: one result per transfer.
// Carries valid, ready and the result fields; uses dvu_pkg for the fold width.
`timescale 1ns / 1ps

interface dvu_result_if #(
  parameter int VEL_WIDTH = 16
) ();
  logic                               valid;
  logic                               ready;
  logic signed [VEL_WIDTH-1:0]        velocity_out;
  logic signed [dvu_pkg::FoldW-1:0]   folds_applied;
  logic                               was_processed;

  modport source (
    output valid, velocity_out, folds_applied, was_processed,
    input  ready
  );

  modport sink (
    input  valid, velocity_out, folds_applied, was_processed,
    output ready
  );
endinterface

// ===== rtl/dvu_mul.sv =====
// Shared two-pass multiplier: one half-width partial product per cycle, accumulated.
// Uses dvu_pkg for the operation codes.
`timescale 1ns / 1ps

module dvu_mul #(
  parameter int AW = 24,
  parameter int BW = 24
) (
  input  logic                  clk_i,
  input  dvu_pkg::mul_op_e      op_i,
  input  logic [AW-1:0]         a_i,
  input  logic [BW-1:0]         b_i,
  output logic [AW+BW-1:0]      prod_o
);
  import dvu_pkg::*;

  localparam int LW = (AW + 1) / 2;
  localparam int HW = AW - LW;
  localparam int PW = AW + BW;

  logic [LW-1:0]    part;
  logic [LW+BW-1:0] pp;
  logic [PW-1:0]    acc_d, acc_q;

  always_comb begin
    part = (op_i == MUL_HI) ? LW'(a_i[AW-1 -: HW]) : a_i[LW-1:0];
    pp   = part * b_i;
  end

  always_comb begin
    unique case (op_i)
      MUL_LO:  acc_d = PW'(pp);
      MUL_HI:  acc_d = acc_q + (PW'(pp) << LW);
      default: acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign prod_o = acc_q;

endmodule

// ===== rtl/dvu_ctrl.sv =====
// Sequencing state machine of the Doppler velocity unfold unit.
// Issues datapath commands from datapath status; uses dvu_pkg.
`timescale 1ns / 1ps

module dvu_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  dvu_pkg::sts_t sts_i,
  output dvu_pkg::cmd_t cmd_o
);
  import dvu_pkg::*;

  ctrl_state_e state_d, state_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (sts_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          priority if (sts_i.seed_now) state_d = ST_FILL;
          else if (sts_i.proc_now)     state_d = ST_MUL1_LO;
          else                         state_d = ST_LOAD;
        end
      end
      ST_FILL: begin
        if (sts_i.fill_last) state_d = sts_i.proc_q ? ST_MUL1_LO : ST_LOAD;
      end
      ST_MUL1_LO: state_d = ST_MUL1_HI;
      ST_MUL1_HI: state_d = ST_DIFF;
      ST_DIFF:    state_d = ST_MUL2_LO;
      ST_MUL2_LO: state_d = ST_MUL2_HI;
      ST_MUL2_HI: state_d = ST_FOLD;
      ST_FOLD:    state_d = ST_UPDATE;
      ST_UPDATE:  state_d = ST_LOAD;
      ST_LOAD: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_op  = MUL_IDLE;
    cmd_o.mul_sel = SEL_AVG;
    in_ready_o    = 1'b0;
    unique case (state_q)
      ST_CLEAR: cmd_o.clear = 1'b1;
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_FILL: cmd_o.fill = 1'b1;
      ST_MUL1_LO: begin
        cmd_o.rd     = 1'b1;
        cmd_o.mul_op = MUL_LO;
      end
      ST_MUL1_HI: cmd_o.mul_op = MUL_HI;
      ST_DIFF:    cmd_o.diff   = 1'b1;
      ST_MUL2_LO: begin
        cmd_o.mul_op  = MUL_LO;
        cmd_o.mul_sel = SEL_FOLD;
      end
      ST_MUL2_HI: begin
        cmd_o.mul_op  = MUL_HI;
        cmd_o.mul_sel = SEL_FOLD;
      end
      ST_FOLD:   cmd_o.fold     = 1'b1;
      ST_UPDATE: cmd_o.upd      = 1'b1;
      ST_LOAD:   cmd_o.load_out = sts_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/dvu_dpath.sv =====
// Datapath of the Doppler velocity unfold unit: ring memory, running sum, seed
// tracking, fold arithmetic and the result register. Uses dvu_pkg and dvu_mul.
`timescale 1ns / 1ps

module dvu_dpath #(
  parameter int MAX_AVG   = 64,
  parameter int VEL_WIDTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  dvu_pkg::cfg_t                     cfg_i,
  input  dvu_pkg::cmd_t                     cmd_i,
  output dvu_pkg::sts_t                     sts_o,
  input  logic signed [VEL_WIDTH-1:0]       gate_velocity_i,
  input  logic                              gate_missing_i,
  input  logic                              in_boundary_i,
  input  logic                              ray_start_i,
  input  logic                              sweep_start_i,
  input  logic signed [VEL_WIDTH-1:0]       wind_velocity_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic signed [VEL_WIDTH-1:0]       velocity_out_o,
  output logic signed [dvu_pkg::FoldW-1:0]  folds_applied_o,
  output logic                              was_processed_o
);
  import dvu_pkg::*;

  localparam int AddrW  = (MAX_AVG > 1) ? $clog2(MAX_AVG) : 1;
  localparam int NW     = $clog2(MAX_AVG + 1);
  localparam int CW     = NW + 1;
  localparam int SW     = VEL_WIDTH + $clog2(MAX_AVG) + 1;
  localparam int SMW    = SW - 1;
  localparam int AMW    = SMW + 1;
  localparam int DMW    = AMW + 1;
  localparam int DCW    = (DMW > 39) ? 39 : DMW;
  localparam int MAW    = (SMW > DCW) ? SMW : DCW;
  localparam int PW     = MAW + FoldRecW;
  localparam int FMW    = PW - 24;
  localparam int FProdW = FoldW + FoldIntW + 1;
  localparam int XW     = ((VEL_WIDTH > FProdW) ? VEL_WIDTH : FProdW) + 1;

  localparam logic [63:0]          DClampMax = 64'd1 << 38;
  localparam logic signed [XW-1:0] VelMax    =
    {{(XW - VEL_WIDTH + 1){1'b0}}, {(VEL_WIDTH - 1){1'b1}}};
  localparam logic signed [XW-1:0] VelMin    = ~VelMax;

  // Ring length and pointer handling.
  logic [8:0]       cnt_ext, n_ext;
  logic [NW-1:0]    ring_n;
  logic [AddrW-1:0] ptr_d, ptr_q, ptr_w, fill_cnt_d, fill_cnt_q;
  logic             fill_last, clear_last;

  // Seed tracking.
  logic                        seed_valid_d, seed_valid_q;
  logic                        seed_pend_d, seed_pend_q;
  logic                        first_pend_d, first_pend_q;
  logic                        sv_eff, pend_rs, seed_rs, seed_vel, seed_now, proc_now;
  logic signed [VEL_WIDTH-1:0] seed_sel, seed_val_q, remembered_q;
  logic signed [SW-1:0]        seed_ext, n_signed, seed_sum;

  // Arithmetic.
  logic signed [SW-1:0]        sum_d, sum_q;
  logic [SW-1:0]               sum_abs;
  logic [MAW-1:0]              mul_a;
  logic [FoldRecW-1:0]         mul_b;
  logic [PW-1:0]               prod, arnd, frnd;
  logic [AMW-1:0]              amag;
  logic signed [AMW:0]         avg;
  logic signed [AMW+1:0]       diff;
  logic [DMW-1:0]              dmag;
  logic [DCW-1:0]              dclamp_d, dclamp_q;
  logic                        diff_neg_q;
  logic [FMW-1:0]              fmag;
  logic [FoldLimW-1:0]         fold_mag;
  logic signed [FoldW-1:0]     folds;
  logic signed [FProdW-1:0]    fprod;
  logic signed [XW-1:0]        xsum;
  logic signed [VEL_WIDTH-1:0] vx_sat;

  // Per-gate work registers.
  logic signed [VEL_WIDTH-1:0] vel_q, vx_q, rd_q;
  logic signed [FoldW-1:0]     folds_q;
  logic                        proc_q;

  // Ring memory write port.
  logic                        wr_en;
  logic [AddrW-1:0]            wr_addr;
  logic signed [VEL_WIDTH-1:0] wr_data;
  logic signed [VEL_WIDTH-1:0] ring_mem [MAX_AVG];

  // Result register.
  logic                        out_valid_d, out_valid_q, out_free;
  logic signed [VEL_WIDTH-1:0] out_vel_q;
  logic signed [FoldW-1:0]     out_folds_q;
  logic                        out_proc_q;

  always_comb begin
    cnt_ext = 9'(cfg_i.avg_count);
    if (cnt_ext == 9'd0) begin
      n_ext = 9'd1;
    end else if (cnt_ext > 9'(MAX_AVG)) begin
      n_ext = 9'(MAX_AVG);
    end else begin
      n_ext = cnt_ext;
    end
    ring_n     = NW'(n_ext);
    ptr_w      = (CW'(ptr_q) >= CW'(ring_n)) ? '0 : ptr_q;
    fill_last  = (CW'(fill_cnt_q) + CW'(1)) >= CW'(ring_n);
    clear_last = (CW'(fill_cnt_q) + CW'(1)) >= CW'(MAX_AVG);
  end

  // The seed for a ray comes from the wind, the remembered gate, or the first
  // non-missing gate, in that order of the mode and what is remembered.
  always_comb begin
    sv_eff   = seed_valid_q & ~(ray_start_i & sweep_start_i & ~cfg_i.init_mode);
    pend_rs  = ray_start_i ? (~cfg_i.init_mode & ~sv_eff) : seed_pend_q;
    seed_rs  = ray_start_i & (cfg_i.init_mode | sv_eff);
    seed_vel = pend_rs & ~gate_missing_i;
    seed_now = seed_rs | seed_vel;
    proc_now = ~gate_missing_i & in_boundary_i;
    if (seed_rs) begin
      seed_sel = cfg_i.init_mode ? wind_velocity_i : remembered_q;
    end else begin
      seed_sel = gate_velocity_i;
    end
    seed_ext = SW'(seed_sel);
    n_signed = SW'($signed({1'b0, ring_n}));
    seed_sum = seed_ext * n_signed;
  end

  always_comb begin
    sum_abs = sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);
    if (cmd_i.mul_sel == SEL_AVG) begin
      mul_a = MAW'(sum_abs[SMW-1:0]);
      mul_b = FoldRecW'(cfg_i.avg_reciprocal);
    end else begin
      mul_a = MAW'(dclamp_q);
      mul_b = cfg_i.fold_reciprocal;
    end
  end

  dvu_mul #(
    .AW (MAW),
    .BW (FoldRecW)
  ) u_mul (
    .clk_i  (clk_i),
    .op_i   (cmd_i.mul_op),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Average, difference to the gate and its limited magnitude.
  always_comb begin
    arnd = prod + PW'(32768);
    amag = arnd[16 +: AMW];
    avg  = sum_q[SW-1] ? -$signed({1'b0, amag}) : $signed({1'b0, amag});
    diff = (AMW + 2)'(avg) - (AMW + 2)'(vel_q);
    dmag = diff[AMW+1] ? DMW'(-diff) : DMW'(diff);
    dclamp_d = (64'(dmag) > DClampMax) ? DCW'(DClampMax) : DCW'(dmag);
  end

  // Fold count, limit, and the saturated unfolded velocity.
  always_comb begin
    frnd = prod + PW'(24'h800000);
    fmag = frnd[24 +: FMW];
    if (diff_neg_q) begin
      fold_mag = (fmag > FMW'(cfg_i.max_neg_folds)) ? cfg_i.max_neg_folds
                                                    : fmag[FoldLimW-1:0];
      folds    = -$signed({1'b0, fold_mag});
    end else begin
      fold_mag = (fmag > FMW'(cfg_i.max_pos_folds)) ? cfg_i.max_pos_folds
                                                    : fmag[FoldLimW-1:0];
      folds    = $signed({1'b0, fold_mag});
    end
    fprod = folds * $signed({1'b0, cfg_i.fold_interval});
    xsum  = XW'(vel_q) + XW'(fprod);
    if (xsum > VelMax) begin
      vx_sat = VEL_WIDTH'(VelMax);
    end else if (xsum < VelMin) begin
      vx_sat = VEL_WIDTH'(VelMin);
    end else begin
      vx_sat = VEL_WIDTH'(xsum);
    end
  end

  always_comb begin
    seed_valid_d = seed_valid_q;
    seed_pend_d  = seed_pend_q;
    first_pend_d = first_pend_q;
    ptr_d        = ptr_q;
    sum_d        = sum_q;
    fill_cnt_d   = fill_cnt_q;
    if (cmd_i.accept) begin
      seed_valid_d = sv_eff;
      seed_pend_d  = pend_rs & gate_missing_i;
      first_pend_d = first_pend_q | ray_start_i;
      if (seed_now) begin
        ptr_d = '0;
        sum_d = seed_sum;
      end
    end
    if (cmd_i.fill || cmd_i.clear) begin
      if (cmd_i.clear ? clear_last : fill_last) begin
        fill_cnt_d = '0;
      end else begin
        fill_cnt_d = fill_cnt_q + AddrW'(1);
      end
    end
    if (cmd_i.rd) begin
      ptr_d = ptr_w;
    end
    if (cmd_i.upd) begin
      sum_d = sum_q + SW'(vx_q) - SW'(rd_q);
      ptr_d = ((CW'(ptr_q) + CW'(1)) >= CW'(ring_n)) ? '0 : ptr_q + AddrW'(1);
      if (first_pend_q) begin
        first_pend_d = 1'b0;
        seed_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_valid_q <= 1'b0;
      seed_pend_q  <= 1'b0;
      first_pend_q <= 1'b0;
      ptr_q        <= '0;
      sum_q        <= '0;
      fill_cnt_q   <= '0;
      proc_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      seed_valid_q <= seed_valid_d;
      seed_pend_q  <= seed_pend_d;
      first_pend_q <= first_pend_d;
      ptr_q        <= ptr_d;
      sum_q        <= sum_d;
      fill_cnt_q   <= fill_cnt_d;
      out_valid_q  <= out_valid_d;
      if (cmd_i.accept) begin
        proc_q <= proc_now;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      vel_q      <= gate_velocity_i;
      vx_q       <= gate_velocity_i;
      folds_q    <= '0;
      seed_val_q <= seed_sel;
    end
    if (cmd_i.diff) begin
      dclamp_q   <= dclamp_d;
      diff_neg_q <= diff[AMW+1];
    end
    if (cmd_i.fold) begin
      vx_q    <= vx_sat;
      folds_q <= folds;
    end
    if (cmd_i.upd && first_pend_q) begin
      remembered_q <= vx_q;
    end
    if (cmd_i.load_out) begin
      out_vel_q   <= vx_q;
      out_folds_q <= folds_q;
      out_proc_q  <= proc_q;
    end
  end

  always_comb begin
    wr_en   = cmd_i.fill | cmd_i.clear | cmd_i.upd;
    wr_addr = cmd_i.upd ? ptr_q : fill_cnt_q;
    if (cmd_i.clear) begin
      wr_data = '0;
    end else if (cmd_i.fill) begin
      wr_data = seed_val_q;
    end else begin
      wr_data = vx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring_mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd) begin
      rd_q <= ring_mem[ptr_w];
    end
  end

  always_comb begin
    out_free    = ~out_valid_q | out_ready_i;
    out_valid_d = cmd_i.load_out | (out_valid_q & ~out_ready_i);
  end

  assign sts_o.seed_now   = seed_now;
  assign sts_o.proc_now   = proc_now;
  assign sts_o.proc_q     = proc_q;
  assign sts_o.fill_last  = fill_last;
  assign sts_o.clear_last = clear_last;
  assign sts_o.out_free   = out_free;

  assign out_valid_o     = out_valid_q;
  assign velocity_out_o  = out_vel_q;
  assign folds_applied_o = out_folds_q;
  assign was_processed_o = out_proc_q;

endmodule

// ===== rtl/doppler_velocity_unfold_unit.sv =====
// Doppler velocity unfold unit, top level: configuration registers, sequencer and
// datapath. Uses dvu_pkg, dvu_gate_if, dvu_result_if, dvu_ctrl and dvu_dpath.
//
// Unfolds radial velocities one gate at a time against a running average of the
// last avg_count unfolded gates. For a processed gate, the average and the fold
// count each pass through one shared multiplier in two half-width steps; the
// difference lies between them, then come the fold, ring update and result load.
// A gate that is missing or outside the boundary is not processed and, unless it
// seeds the ring, goes straight to the result register. A seeding gate first
// fills avg_count ring entries (clamped to 1..MAX_AVG), one per cycle through
// the ring write port. After reset all MAX_AVG ring entries are cleared, during
// which no gate is taken; configuration writes are taken at any time. Results
// wait in an output register, so the next gate can be taken while one is pending.
`timescale 1ns / 1ps

module doppler_velocity_unfold_unit #(
  parameter int MAX_AVG   = 64,
  parameter int VEL_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  dvu_gate_if.sink                       gate_i,
  dvu_result_if.source                   result_o,
  input  logic                           cfg_we_i,
  input  logic [dvu_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [dvu_pkg::CfgDataW-1:0]   cfg_data_i
);
  import dvu_pkg::*;

  cfg_t cfg_d, cfg_q;
  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_INIT_MODE:     cfg_d.init_mode       = cfg_data_i[0];
        CFG_AVG_COUNT:     cfg_d.avg_count       = cfg_data_i[AvgCntW-1:0];
        CFG_AVG_RECIP:     cfg_d.avg_reciprocal  = cfg_data_i[AvgRecW-1:0];
        CFG_FOLD_INTERVAL: cfg_d.fold_interval   = cfg_data_i[FoldIntW-1:0];
        CFG_FOLD_RECIP:    cfg_d.fold_reciprocal = cfg_data_i[FoldRecW-1:0];
        CFG_MAX_POS_FOLDS: cfg_d.max_pos_folds   = cfg_data_i[FoldLimW-1:0];
        CFG_MAX_NEG_FOLDS: cfg_d.max_neg_folds   = cfg_data_i[FoldLimW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.init_mode       <= 1'b0;
      cfg_q.avg_count       <= AvgCntRst;
      cfg_q.avg_reciprocal  <= AvgRecRst;
      cfg_q.fold_interval   <= FoldIntRst;
      cfg_q.fold_reciprocal <= FoldRecRst;
      cfg_q.max_pos_folds   <= FoldLimRst;
      cfg_q.max_neg_folds   <= FoldLimRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  dvu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (gate_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dvu_dpath #(
    .MAX_AVG   (MAX_AVG),
    .VEL_WIDTH (VEL_WIDTH)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .gate_velocity_i (gate_i.gate_velocity),
    .gate_missing_i  (gate_i.gate_missing),
    .in_boundary_i   (gate_i.in_boundary),
    .ray_start_i     (gate_i.ray_start),
    .sweep_start_i   (gate_i.sweep_start),
    .wind_velocity_i (gate_i.wind_velocity),
    .out_ready_i     (result_o.ready),
    .out_valid_o     (result_o.valid),
    .velocity_out_o  (result_o.velocity_out),
    .folds_applied_o (result_o.folds_applied),
    .was_processed_o (result_o.was_processed)
  );

  assign gate_i.ready = in_ready;

endmodule
